/* sv/cslm_pkg.sv */
// Package: payload types, error codes and sequencer states for the lock manager.
package cslm_pkg;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_UNHELD   = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;
    localparam int MAX_RESULTS = 32;
    localparam logic [7:0] HOLDER_MAX = 8'd255;

    typedef struct packed {
        logic        action;
        logic [2:0]  lock_index;
        logic [31:0] request_id;
    } in_item_t;

    typedef struct packed {
        logic       grant_valid;
        logic [2:0] granted_lock;
        logic       last;
        logic [1:0] error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage

/* sv/conflict_set_lock_manager.sv */
// Top level: conflict-set lock manager with an iterative grant checker.
//
// Channel   Signals                        Handshake
// config    cfg_we, cfg_data               written when cfg_we high
// input     start, busy, in_item           accepted when start & !busy
// result    out_valid, out_item            one cycle per result, no stall
//
// A queued request steps through the head, scan, decide and emit states;
// the scan visits each lock. A release repeats them for each candidate
// lock tried in each retry pass; results leave back to back at the end.
// One shared compare unit visits one lock per cycle during a scan.
// Reset clears holders, queue pointers and the conflict matrix; queue ids
// are undefined until written. Results cannot be stalled.
module conflict_set_lock_manager #(
    parameter int NUM_LOCKS   = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [63:0]           cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  cslm_pkg::in_item_t    in_item,
    output logic                  out_valid,
    output cslm_pkg::out_item_t   out_item
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = 3;
    localparam int MW = $clog2(NUM_LOCKS * QUEUE_DEPTH);
    localparam int RW = 6;

    logic [63:0]     matrix_reg;
    logic [31:0]     ids_mem [NUM_LOCKS*QUEUE_DEPTH];
    logic [QW-1:0]   head_reg  [NUM_LOCKS];
    logic [CW-1:0]   count_reg [NUM_LOCKS];
    logic [7:0]      holder_reg [NUM_LOCKS];
    logic [LW-1:0]   grant_list [cslm_pkg::MAX_RESULTS];

    cslm_pkg::state_t state_reg, state_next;
    logic            rel_reg;            // release run
    logic [LW-1:0]   base_reg;           // lock requested/released
    logic [LW-1:0]   cand_reg;           // lock under trial
    logic [LW:0]     pos_reg;            // position in retry pass (0 = base)
    logic            progress_reg;
    logic [LW:0]     j_reg;              // scan index
    logic            blocked_reg;
    logic [31:0]     cand_id_reg;
    logic [31:0]     j_id_reg;           // head id of the scanned lock
    logic [1:0]      err_reg;
    logic [RW-1:0]   n_reg;              // grants collected
    logic [RW-1:0]   e_reg;              // results sent

    function automatic logic [MW-1:0] qaddr(logic [LW-1:0] l, logic [QW-1:0] p);
        logic [MW+LW:0] a;
        a = (MW+LW+1)'(l) * (MW+LW+1)'(QUEUE_DEPTH) + (MW+LW+1)'(p);
        return a[MW-1:0];
    endfunction

    // Head id lookup: candidate head, and scan head fetched one lock ahead
    logic [LW-1:0]   jl;
    logic [LW-1:0]   jf;
    logic [MW-1:0]   j_addr, c_addr;
    assign jl = j_reg[LW-1:0];
    assign jf = (state_reg == cslm_pkg::ST_HEAD) ? '0 : LW'(j_reg + 1'b1);
    assign j_addr = qaddr(jf, head_reg[jf]);
    assign c_addr = qaddr(cand_reg, head_reg[cand_reg]);

    // Tail slot of the addressed queue, wrapped by compare and subtract
    logic            in_range;
    logic            q_full;
    logic            acc_write;
    logic [CW:0]     wr_sum;
    logic [QW-1:0]   wr_slot;
    logic [MW-1:0]   wr_addr;
    assign in_range = (32'(in_item.lock_index) < NUM_LOCKS);
    assign q_full = (32'(count_reg[in_item.lock_index]) >= QUEUE_DEPTH);
    assign wr_sum = (CW+1)'(head_reg[in_item.lock_index]) +
                    (CW+1)'(count_reg[in_item.lock_index]);
    assign wr_slot = (wr_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     QW'(wr_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(wr_sum);
    assign wr_addr = qaddr(in_item.lock_index, wr_slot);
    assign acc_write = (state_reg == cslm_pkg::ST_IDLE) && start && in_range &&
                       (in_item.action == cslm_pkg::ACT_REQUEST) && !q_full;

    logic conf_j;
    assign conf_j = matrix_reg[{cand_reg, jl}] && (32'(jl) < NUM_LOCKS);

    // Next candidate in the retry pass after pos_reg
    logic [LW:0] next_pos;
    logic        next_found;
    always_comb
    begin
        next_pos = LW'(0) + (LW+1)'(NUM_LOCKS);
        next_found = 1'b0;
        for (int k = NUM_LOCKS - 1; k >= 0; k--)
        begin
            if ((k + 1) > int'(pos_reg) && matrix_reg[{base_reg, LW'(k)}])
            begin
                next_pos = (LW+1)'(k + 1);
                next_found = 1'b1;
            end
        end
    end

    logic grant_ok;
    assign grant_ok = !blocked_reg && (count_reg[cand_reg] != '0) &&
                      (holder_reg[cand_reg] < cslm_pkg::HOLDER_MAX);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cslm_pkg::ST_IDLE:
                if (start)
                begin
                    if (!in_range)
                        state_next = cslm_pkg::ST_DONE;
                    else if (in_item.action == cslm_pkg::ACT_REQUEST)
                        state_next = q_full ? cslm_pkg::ST_DONE : cslm_pkg::ST_HEAD;
                    else if (holder_reg[in_item.lock_index] == '0)
                        state_next = cslm_pkg::ST_DONE;
                    else
                        state_next = cslm_pkg::ST_HEAD;
                end
            cslm_pkg::ST_HEAD:   state_next = cslm_pkg::ST_SCAN;
            cslm_pkg::ST_SCAN:
                if (32'(j_reg) == NUM_LOCKS - 1) state_next = cslm_pkg::ST_DECIDE;
            cslm_pkg::ST_DECIDE: state_next = cslm_pkg::ST_EMIT;
            cslm_pkg::ST_EMIT:
                if (!rel_reg || 32'(n_reg) >= cslm_pkg::MAX_RESULTS)
                    state_next = cslm_pkg::ST_DONE;
                else if (next_found || progress_reg)
                    state_next = cslm_pkg::ST_HEAD;
                else
                    state_next = cslm_pkg::ST_DONE;
            cslm_pkg::ST_DONE:
                if (n_reg == '0 || e_reg == n_reg - 1'b1)
                    state_next = cslm_pkg::ST_IDLE;
            default:             state_next = cslm_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != cslm_pkg::ST_IDLE);

    // Queue id store, head id reads and grant list
    always_ff @(posedge clk)
    begin
        if (acc_write)
            ids_mem[wr_addr] <= in_item.request_id;
        if (state_reg == cslm_pkg::ST_HEAD)
            cand_id_reg <= ids_mem[c_addr];
        j_id_reg <= ids_mem[j_addr];
        if (state_reg == cslm_pkg::ST_DECIDE && grant_ok)
            grant_list[n_reg[4:0]] <= cand_reg;
    end

    // Sequencer registers and state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cslm_pkg::ST_IDLE;
            matrix_reg <= '0;
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                head_reg[i] <= '0;
                count_reg[i] <= '0;
                holder_reg[i] <= '0;
            end
            out_valid <= 1'b0;
            out_item <= '0;
            rel_reg <= 1'b0;
            base_reg <= '0;
            cand_reg <= '0;
            pos_reg <= '0;
            progress_reg <= 1'b0;
            j_reg <= '0;
            blocked_reg <= 1'b0;
            err_reg <= '0;
            n_reg <= '0;
            e_reg <= '0;
        end
        else
        begin
            out_valid <= 1'b0;
            if (cfg_we) matrix_reg <= cfg_data;
            state_reg <= state_next;
            case (state_reg)
                cslm_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        rel_reg <= in_item.action;
                        base_reg <= in_item.lock_index;
                        cand_reg <= in_item.lock_index;
                        pos_reg <= '0;
                        progress_reg <= 1'b0;
                        err_reg <= cslm_pkg::ERR_NONE;
                        n_reg <= '0;
                        e_reg <= '0;
                        if (!in_range)
                            ;
                        else if (in_item.action == cslm_pkg::ACT_REQUEST)
                        begin
                            if (q_full)
                                err_reg <= cslm_pkg::ERR_FULL;
                            else
                                count_reg[in_item.lock_index] <=
                                    count_reg[in_item.lock_index] + 1'b1;
                        end
                        else if (holder_reg[in_item.lock_index] == '0)
                            err_reg <= cslm_pkg::ERR_UNHELD;
                        else
                            holder_reg[in_item.lock_index] <=
                                holder_reg[in_item.lock_index] - 1'b1;
                    end
                end
                cslm_pkg::ST_HEAD:
                begin
                    // start the scan at lock 0
                    blocked_reg <= 1'b0;
                    j_reg <= '0;
                end
                cslm_pkg::ST_SCAN:
                begin
                    // shared compare: one lock per cycle
                    if (conf_j && ((holder_reg[jl] != '0) ||
                        (count_reg[jl] != '0 && j_id_reg < cand_id_reg)))
                        blocked_reg <= 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                cslm_pkg::ST_DECIDE:
                begin
                    if (!blocked_reg && count_reg[cand_reg] != '0 && !grant_ok)
                        err_reg <= cslm_pkg::ERR_OVERFLOW;
                    if (grant_ok)
                    begin
                        head_reg[cand_reg] <=
                            (32'(head_reg[cand_reg]) == QUEUE_DEPTH - 1) ?
                            '0 : head_reg[cand_reg] + 1'b1;
                        count_reg[cand_reg] <= count_reg[cand_reg] - 1'b1;
                        holder_reg[cand_reg] <= holder_reg[cand_reg] + 1'b1;
                        progress_reg <= 1'b1;
                        n_reg <= n_reg + 1'b1;
                    end
                end
                cslm_pkg::ST_EMIT:
                begin
                    // advance to next candidate, start a new pass, or end the run
                    if (!rel_reg || 32'(n_reg) >= cslm_pkg::MAX_RESULTS)
                        ;
                    else if (next_found)
                    begin
                        pos_reg <= next_pos;
                        cand_reg <= LW'(next_pos - 1'b1);
                    end
                    else if (progress_reg)
                    begin
                        progress_reg <= 1'b0;
                        pos_reg <= '0;
                        cand_reg <= base_reg;
                    end
                end
                cslm_pkg::ST_DONE:
                begin
                    // send collected grants, or one empty result
                    out_valid <= 1'b1;
                    if (n_reg == '0)
                        out_item <= '{1'b0, 3'd0, 1'b1, err_reg};
                    else
                    begin
                        out_item <= '{1'b1, grant_list[e_reg[4:0]],
                                      (e_reg == n_reg - 1'b1), err_reg};
                        e_reg <= e_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // A result is only shown while a run is in progress
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(busy))
        else $error("result outside a run");
    // No more than the result limit per run
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (32'(n_reg) <= cslm_pkg::MAX_RESULTS))
        else $error("grant limit exceeded");
    // The final result always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.last) |-> !busy)
        else $error("last result without run end");
endmodule

/* verif/conflict_set_lock_manager_tb.sv */
// Testbench: drives lock requests and releases and checks grant results against a predictor.
module conflict_set_lock_manager_tb;

    localparam int LOCKS = 8;
    localparam int DEPTH = 4;
    localparam int IDLE_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [63:0]           cfg_data;
    logic                  start;
    logic                  busy;
    cslm_pkg::in_item_t    in_item;
    logic                  out_valid;
    cslm_pkg::out_item_t   out_item;

    conflict_set_lock_manager #(.NUM_LOCKS(LOCKS), .QUEUE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .in_item(in_item),
        .out_valid(out_valid), .out_item(out_item)
    );

    // Predictor state
    logic [63:0] conflict_bits;
    logic [31:0] queue_ids [LOCKS][DEPTH];
    int          queue_head [LOCKS];
    int          queue_count [LOCKS];
    int          holders [LOCKS];

    cslm_pkg::in_item_t    pending_items [$];
    cslm_pkg::out_item_t   expected_grants [$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    bit          driver_on;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic bit lock_blocks(int i, int j);
        return conflict_bits[i * 8 + j];
    endfunction

    // Try to grant the head of lock i; update predictor state on success
    function automatic bit grant_head(int i, inout logic [1:0] err);
        logic [31:0] id;
        if (queue_count[i] == 0)
            return 1'b0;
        id = queue_ids[i][queue_head[i]];
        for (int j = 0; j < LOCKS; j++)
        begin
            if (!lock_blocks(i, j))
                continue;
            if (holders[j] > 0)
                return 1'b0;
            if (queue_count[j] > 0 && queue_ids[j][queue_head[j]] < id)
                return 1'b0;
        end
        if (holders[i] >= cslm_pkg::HOLDER_MAX)
        begin
            err = cslm_pkg::ERR_OVERFLOW;
            return 1'b0;
        end
        queue_head[i] = (queue_head[i] + 1) % DEPTH;
        queue_count[i]--;
        holders[i]++;
        return 1'b1;
    endfunction

    // Compute the grant run for one accepted transaction
    task automatic predict_grants(cslm_pkg::in_item_t it);
        int                    granted [$];
        logic [1:0]            err;
        int                    lk;
        bit                    progress;
        cslm_pkg::out_item_t   res;
        err = cslm_pkg::ERR_NONE;
        lk = it.lock_index;
        if (it.action == cslm_pkg::ACT_REQUEST)
        begin
            if (queue_count[lk] >= DEPTH)
                err = cslm_pkg::ERR_FULL;
            else
            begin
                queue_ids[lk][(queue_head[lk] + queue_count[lk]) % DEPTH] = it.request_id;
                queue_count[lk]++;
                if (grant_head(lk, err))
                    granted.push_back(lk);
            end
        end
        else if (holders[lk] == 0)
            err = cslm_pkg::ERR_UNHELD;
        else
        begin
            holders[lk]--;
            do
            begin
                progress = 1'b0;
                for (int c = -1; c < LOCKS; c++)
                begin
                    if (c >= 0 && !lock_blocks(lk, c))
                        continue;
                    if (granted.size() >= cslm_pkg::MAX_RESULTS)
                        continue;
                    if (grant_head(c < 0 ? lk : c, err))
                    begin
                        granted.push_back(c < 0 ? lk : c);
                        progress = 1'b1;
                    end
                end
            end while (progress && granted.size() < cslm_pkg::MAX_RESULTS);
        end
        if (granted.size() == 0)
        begin
            res = '{grant_valid: 1'b0, granted_lock: 3'd0, last: 1'b1, error: err};
            expected_grants.push_back(res);
        end
        foreach (granted[k])
        begin
            res.grant_valid = 1'b1;
            res.granted_lock = 3'(granted[k]);
            res.last = (k == granted.size() - 1);
            res.error = err;
            expected_grants.push_back(res);
        end
    endtask

    // Driver: present queued transactions in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_grants(in_item);
                void'(pending_items.pop_front());
            end
            if (start && busy)
                ;
            else if (!driver_on || pending_items.size() == 0 ||
                     (start && !busy && pending_items.size() == 0))
                start <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                in_item <= pending_items[0];
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            if (expected_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p", out_item);
            end
            else
            begin
                if (out_item !== expected_grants[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p got %p", expected_grants[0], out_item);
                end
                void'(expected_grants.pop_front());
            end
        end
    end

    // Watchdog: count cycles with no accepted transaction or result
    always @(posedge clk)
    begin
        if (!rst_n || out_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_item(logic act, int lk, logic [31:0] id);
        cslm_pkg::in_item_t it;
        it.action = act;
        it.lock_index = 3'(lk);
        it.request_id = id;
        pending_items.push_back(it);
    endtask

    // Run a phase: feed items, wait until all results have arrived
    task automatic run_phase();
        driver_on = 1'b1;
        while (pending_items.size() > 0)
            @(posedge clk);
        @(posedge clk);
        @(posedge clk);
        while (busy || expected_grants.size() > 0)
            @(posedge clk);
        driver_on = 1'b0;
        repeat (300) @(posedge clk);
    endtask

    task automatic write_matrix(logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        conflict_bits = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random workload: mostly requests, most with non-decreasing ids, and releases of random locks
    task automatic random_phase(int count, inout logic [31:0] next_id);
        int lk;
        for (int n = 0; n < count; n++)
        begin
            lk = $urandom_range(0, LOCKS - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    add_item(cslm_pkg::ACT_RELEASE, lk, $urandom);
                9:
                    add_item(cslm_pkg::ACT_REQUEST, lk, $urandom);
                default:
                begin
                    next_id += $urandom_range(0, 3);
                    add_item(cslm_pkg::ACT_REQUEST, lk, next_id);
                end
            endcase
        end
    endtask

    initial
    begin
        logic [31:0] next_id;
        mismatches = 0;
        driver_on = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_item = '0;
        start = 1'b0;
        conflict_bits = '0;
        for (int i = 0; i < LOCKS; i++)
        begin
            queue_head[i] = 0;
            queue_count[i] = 0;
            holders[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no conflicts, unheld release, field extremes
        add_item(cslm_pkg::ACT_RELEASE, 3, 32'hFFFF_FFFF);
        add_item(cslm_pkg::ACT_REQUEST, 0, 32'h0000_0000);
        add_item(cslm_pkg::ACT_REQUEST, 7, 32'hFFFF_FFFF);
        add_item(cslm_pkg::ACT_RELEASE, 0, 32'h0);
        add_item(cslm_pkg::ACT_RELEASE, 7, 32'h0);
        run_phase();

        // All locks conflict, self conflict included: queue, fill, release
        write_matrix(64'hFFFF_FFFF_FFFF_FFFF);
        add_item(cslm_pkg::ACT_REQUEST, 2, 32'd10);
        for (int k = 0; k < 5; k++)
            add_item(cslm_pkg::ACT_REQUEST, 2, 32'd20 + k);
        add_item(cslm_pkg::ACT_REQUEST, 5, 32'd15);
        add_item(cslm_pkg::ACT_REQUEST, 6, 32'd15);
        add_item(cslm_pkg::ACT_RELEASE, 2, 32'h0);
        add_item(cslm_pkg::ACT_RELEASE, 5, 32'h0);
        add_item(cslm_pkg::ACT_RELEASE, 6, 32'h0);
        add_item(cslm_pkg::ACT_RELEASE, 2, 32'h0);
        run_phase();

        // Self conflict on locks 0 and 1, equal ids and holder blocking
        write_matrix(64'h0000_0000_0000_0201);
        add_item(cslm_pkg::ACT_REQUEST, 0, 32'd100);
        add_item(cslm_pkg::ACT_REQUEST, 1, 32'd100);
        add_item(cslm_pkg::ACT_REQUEST, 1, 32'd101);
        add_item(cslm_pkg::ACT_RELEASE, 0, 32'h0);
        run_phase();

        // Many holders per lock, no conflicts
        write_matrix(64'h0);
        next_id = 32'd1000;
        random_phase(100, next_id);
        run_phase();

        write_matrix({$urandom, $urandom});
        random_phase(100, next_id);
        run_phase();

        write_matrix(64'h8040_2010_0804_0201 | {$urandom, $urandom} & {$urandom, $urandom});
        random_phase(100, next_id);
        run_phase();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* conflict_set_lock_manager.f */
sv/cslm_pkg.sv
sv/conflict_set_lock_manager.sv
verif/conflict_set_lock_manager_tb.sv
